FILE: rtl/core/clir_pkg.sv
// ----------------------------------------------------------------------------
// clir_pkg
// Types and constants shared by the circular list block: beat structs,
// operation codes and result status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package clir_pkg;

  // default number of list entries
  localparam int DEPTH_DEF = 16;

  // operation codes of an input beat
  localparam logic [1:0] FN_APPEND = 2'd0;
  localparam logic [1:0] FN_LIST   = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  // input beat
  typedef struct packed {
    logic [1:0]         func;
    logic signed [31:0] value;
  } req_t;

  // result beat
  typedef struct packed {
    logic signed [31:0] item_value;
    status_t            status;
    logic               last;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/circular_list_insert_remove.sv
// Timing: append gives its status beat from S_DONE after acceptance; list
// gives one beat per stored entry, each from S_EVAL after an S_READ, and
// remove walks all n entries through S_READ and S_EVAL, then S_DONE.
// Throughput: one item at a time; result stalls hold it further. It is set by the
// single read port of the entry store walked one entry per read/compare pair.
// Reset clears the entry count and sequencer; entries are not cleared.
// ----------------------------------------------------------------------------
// circular_list_insert_remove
// Ordered list of signed 32-bit values with append, list and remove of all
// entries equal to a key, built as a sequencer over a one-read one-write store.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_list_insert_remove #(
  parameter int DEPTH = clir_pkg::DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire clir_pkg::req_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output clir_pkg::res_t      out_data
);

  import clir_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [31:0]   mem_rdata;

  // entry store
  clir_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // sequencer and result register
  clir_seq #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

`default_nettype wire

FILE: rtl/core/clir_mem.sv
// ----------------------------------------------------------------------------
// clir_mem
// Entry store of the list: one write port and one read port with
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module clir_mem #(
  parameter int DEPTH = clir_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [31:0]   wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [31:0]        rdata
);

  logic [31:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/clir_seq.sv
// ----------------------------------------------------------------------------
// clir_seq
// Sequencer of the circular list: takes one beat at a time, walks the
// stored entries through the shared compare unit and drives the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module clir_seq #(
  parameter int DEPTH = clir_pkg::DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire clir_pkg::req_t in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output clir_pkg::res_t     out_data,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output logic [31:0]        mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  wire logic [31:0]   mem_rdata
);

  import clir_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_EVAL = 4'b0100,
    S_DONE = 4'b1000
  } seq_state_t;

  seq_state_t  state_r, state_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] kept_r, kept_nxt;
  logic        found_r, found_nxt;
  logic [1:0]  func_r, func_nxt;
  logic [31:0] key_r, key_nxt;
  status_t     status_r, status_nxt;
  logic        out_valid_r;
  res_t        out_data_r;
  logic        out_ld;
  res_t        out_ld_data;
  logic        accept;
  logic        out_free;
  logic        match;
  logic        at_end;

  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared compare unit and walk end detect
  assign match  = (mem_rdata == key_r);
  assign at_end = ((CW'(idx_r) + CW'(1)) == count_r);

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    kept_nxt    = kept_r;
    found_nxt   = found_r;
    func_nxt    = func_r;
    key_nxt     = key_r;
    status_nxt  = status_r;
    mem_we      = 1'b0;
    mem_waddr   = count_r[AW-1:0];
    mem_wdata   = in_data.value;
    mem_raddr   = idx_r;
    out_ld      = 1'b0;
    out_ld_data = '{item_value: '0, status: status_r, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          func_nxt  = in_data.func;
          key_nxt   = in_data.value;
          idx_nxt   = '0;
          kept_nxt  = '0;
          found_nxt = 1'b0;
          case (in_data.func)
            FN_APPEND: begin
              if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                count_nxt  = count_r + CW'(1);
                status_nxt = ST_OK;
              end
              state_nxt = S_DONE;
            end
            FN_LIST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            FN_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_NOT_FOUND;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_READ;
              end
            end
            default: begin
              // unused code: beat is dropped without a result
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (func_r == FN_LIST) begin
          // one result beat per entry
          if (out_free) begin
            out_ld      = 1'b1;
            out_ld_data = '{item_value: mem_rdata, status: ST_OK, last: at_end};
            if (at_end) begin
              state_nxt = S_IDLE;
            end else begin
              idx_nxt   = idx_r + AW'(1);
              state_nxt = S_READ;
            end
          end
        end else begin
          // compact the entries that do not match the key
          found_nxt = found_r || match;
          if (!match) begin
            mem_we    = 1'b1;
            mem_waddr = kept_r[AW-1:0];
            mem_wdata = mem_rdata;
            kept_nxt  = kept_r + CW'(1);
          end
          if (at_end) begin
            count_nxt  = kept_nxt;
            status_nxt = found_nxt ? ST_OK : ST_NOT_FOUND;
            state_nxt  = S_DONE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_READ;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // walk and payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    kept_r   <= kept_nxt;
    found_r  <= found_nxt;
    func_r   <= func_nxt;
    key_r    <= key_nxt;
    status_r <= status_nxt;
    if (out_ld) begin
      out_data_r <= out_ld_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/clir_chk.sv
// ----------------------------------------------------------------------------
// clir_chk
// Port checker for the circular list block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module clir_chk (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire clir_pkg::req_t in_data,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire clir_pkg::res_t out_data
);

  import clir_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // the block is busy after taking a real operation
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall &&
    (in_data.func == FN_APPEND || in_data.func == FN_LIST ||
     in_data.func == FN_REMOVE) |=> in_stall)
    else $error("input taken while previous item in flight");

  // a status other than ok always ends the item
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.last)
    else $error("error status without last");

  // status-only results carry a zero value
  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> (out_data.item_value == '0))
    else $error("status beat with nonzero value");

endmodule

bind circular_list_insert_remove clir_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: dv/clir_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// clir_checker
// Watches both channels of the circular list block. It keeps its own copy of
// the stored values, works out the result beats of every accepted request
// and compares each accepted result beat, field by field, with the oldest
// one still waiting.
// ----------------------------------------------------------------------------

module clir_checker #(
  parameter int DEPTH = clir_pkg::DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  clir_pkg::req_t in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  clir_pkg::res_t out_data,
  output int             fail_count,
  output int             pending_beats
);

  import clir_pkg::*;

  // mirror of the stored values, oldest first
  logic signed [31:0] held_vals [DEPTH];
  int                 held_count;

  // result beats owed by the block, oldest first
  res_t list_answers [$];

  initial begin
    fail_count    = 0;
    pending_beats = 0;
    held_count    = 0;
  end

  task automatic owe_beat(input logic signed [31:0] v, input status_t st, input logic lst);
    res_t r;
    r.item_value = v;
    r.status     = st;
    r.last       = lst;
    list_answers.push_back(r);
  endtask

  // apply one request to the mirror and queue the beats it causes
  task automatic apply_request(input req_t req);
    int kept;
    bit hit;
    kept = 0;
    hit  = 1'b0;
    case (req.func)
      FN_APPEND: begin
        if (held_count >= DEPTH) begin
          owe_beat('0, ST_FULL, 1'b1);
        end else begin
          held_vals[held_count] = req.value;
          held_count++;
          owe_beat('0, ST_OK, 1'b1);
        end
      end
      FN_LIST: begin
        if (held_count == 0) begin
          owe_beat('0, ST_EMPTY, 1'b1);
        end else begin
          for (int i = 0; i < held_count; i++)
            owe_beat(held_vals[i], ST_OK, i == held_count - 1);
        end
      end
      FN_REMOVE: begin
        // drop every match, close the gaps in order
        for (int i = 0; i < held_count; i++) begin
          if (held_vals[i] == req.value) begin
            hit = 1'b1;
          end else begin
            held_vals[kept] = held_vals[i];
            kept++;
          end
        end
        held_count = kept;
        owe_beat('0, hit ? ST_OK : ST_NOT_FOUND, 1'b1);
      end
      default: ;  // unused code, no beat and no change
    endcase
  endtask

  task automatic check_beat(input res_t got);
    res_t want;
    if (list_answers.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected result beat: value %0d status %0d last %0b",
                 got.item_value, got.status, got.last);
    end else begin
      want = list_answers.pop_front();
      if (got.item_value !== want.item_value || got.status !== want.status ||
          got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10)
          $display({"result mismatch: got value %0d status %0d last %0b, ",
                    "want value %0d status %0d last %0b"},
                   got.item_value, got.status, got.last,
                   want.item_value, want.status, want.last);
      end
    end
  endtask

  // sample both channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      list_answers.delete();
    end else begin
      if (out_valid && !out_stall)
        check_beat(out_data);
      if (in_valid && !in_stall)
        apply_request(in_data);
    end
    pending_beats = list_answers.size();
  end

endmodule

FILE: dv/tb_circular_list_insert_remove.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_circular_list_insert_remove
// Drives append, list and remove requests into the circular list block with
// random bursts and gaps while the result side stalls on its own pattern.
// A directed opening covers the empty, full and duplicate cases; random
// requests follow. The checker beside the block does all comparing.
// ----------------------------------------------------------------------------

module tb_circular_list_insert_remove;
  import clir_pkg::*;

  localparam int         DEPTH        = DEPTH_DEF;
  localparam logic [1:0] FN_UNUSED    = 2'd3;
  localparam int         RANDOM_ITEMS = 150;
  localparam int         CYCLE_LIMIT  = 300000;
  localparam int         DRAIN_CYCLES = 2 * DEPTH + 8;

  localparam logic signed [31:0] VAL_MIN  = 32'h8000_0000;
  localparam logic signed [31:0] VAL_MAX  = 32'h7FFF_FFFF;
  localparam logic signed [31:0] VAL_ODD  = 32'h5555_5555;
  localparam logic signed [31:0] VAL_EVEN = 32'hAAAA_AAAA;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  req_t in_data   = '0;
  logic in_stall;
  logic out_valid;
  res_t out_data;

  int fail_count;
  int pending_beats;
  int cycle_count = 0;

  // sender burst and receiver stall state
  int burst_left       = 0;
  bit valid_held       = 1'b0;
  int stall_phase_left = 0;
  int stall_mode       = 0;

  // random request shaping
  logic signed [31:0] key_pool [8];
  logic signed [31:0] corner_vals [6];
  bit                 fill_bias = 1'b1;
  int                 bias_left = 0;

  always #2 clk = ~clk;

  circular_list_insert_remove #(
    .DEPTH(DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  clir_checker #(
    .DEPTH(DEPTH)
  ) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .fail_count   (fail_count),
    .pending_beats(pending_beats)
  );

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver stall pattern: free running, light or heavy phases
  always @(negedge clk) begin
    if (stall_phase_left == 0) begin
      stall_mode       <= $urandom_range(0, 2);
      stall_phase_left <= $urandom_range(20, 80);
    end else begin
      stall_phase_left <= stall_phase_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // idle cycles after the current beat: zero inside a burst
  function automatic int next_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    burst_left = $urandom_range(0, 30);
    return $urandom_range(1, 6);
  endfunction

  // present one request beat at the falling edge and hold it until taken
  task automatic push_request(input logic [1:0] fn, input logic signed [31:0] v);
    int   gap;
    req_t req;
    gap       = next_gap();
    req.func  = fn;
    req.value = v;
    in_data  <= req;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    valid_held = (gap == 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // mostly keys that repeat, so removes hit, with corners and raw noise
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return key_pool[$urandom_range(0, 7)];
      6:                return corner_vals[$urandom_range(0, 5)];
      default:          return $urandom;
    endcase
  endfunction

  // fill phases push toward full, drain phases favor removes
  function automatic logic [1:0] pick_func();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5)
      return FN_UNUSED;
    if (fill_bias)
      return (roll < 70) ? FN_APPEND : ((roll < 82) ? FN_LIST : FN_REMOVE);
    return (roll < 30) ? FN_APPEND : ((roll < 50) ? FN_LIST : FN_REMOVE);
  endfunction

  // empty list, extremes, duplicates, head removal, full list
  task automatic run_directed();
    push_request(FN_LIST, 32'sd0);
    push_request(FN_REMOVE, 32'sd5);
    push_request(FN_APPEND, VAL_MIN);
    push_request(FN_APPEND, VAL_MAX);
    push_request(FN_APPEND, 32'sd0);
    push_request(FN_APPEND, -32'sd1);
    push_request(FN_APPEND, VAL_MAX);
    push_request(FN_LIST, VAL_MAX);
    push_request(FN_REMOVE, VAL_MAX);
    push_request(FN_UNUSED, -32'sd1);
    push_request(FN_REMOVE, VAL_MIN);
    for (int i = 0; i < DEPTH - 2; i++)
      push_request(FN_APPEND, i[0] ? VAL_EVEN : VAL_ODD);
    push_request(FN_APPEND, 32'sd77);
    push_request(FN_LIST, -32'sd1);
    push_request(FN_REMOVE, VAL_ODD);
  endtask

  initial begin
    int         counted;
    logic [1:0] fn;
    counted        = 0;
    corner_vals[0] = VAL_MIN;
    corner_vals[1] = VAL_MAX;
    corner_vals[2] = 32'sd0;
    corner_vals[3] = -32'sd1;
    corner_vals[4] = VAL_ODD;
    corner_vals[5] = VAL_EVEN;
    for (int i = 0; i < 8; i++)
      key_pool[i] = ($urandom_range(0, 3) == 0) ? $urandom
                                                : $signed($urandom_range(0, 20)) - 10;

    // hold reset, then release at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    // random requests; unused codes do not count
    while (counted < RANDOM_ITEMS) begin
      if (bias_left == 0) begin
        fill_bias = $urandom_range(0, 1);
        bias_left = $urandom_range(8, 30);
      end
      bias_left--;
      fn = pick_func();
      push_request(fn, pick_value());
      if (fn != FN_UNUSED)
        counted++;
    end
    if (valid_held)
      in_valid <= 1'b0;

    // drain the owed beats, then watch for strays
    while (pending_beats != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending_beats == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
